// ===== rtl/m4adj_pkg.sv =====
`timescale 1ns / 1ps
package m4adj_pkg;

  localparam int DEF_ELEM_WIDTH = 32;
  localparam int DEF_FRAC_BITS  = 16;
  localparam int THR_WIDTH      = 16;
  localparam logic [3:0] LAST_STEP  = 4'd8;
  localparam logic [3:0] LAST_INDEX = 4'd15;
  localparam logic [63:0] S64_MAX_MAG = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef logic signed [63:0] wide_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_FETCH_A,
    ST_FETCH_B,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_APPLY,
    ST_CHECK,
    ST_SING_OUT,
    ST_DIV_FETCH,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DIV_OUT
  } state_t;

  // saturating add on signed 64 bits
  function automatic wide_t sat_add(wide_t a, wide_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? wide_t'({1'b1, 63'b0}) : wide_t'({1'b0, {63{1'b1}}});
    end
    return s[63:0];
  endfunction

  // saturating negate
  function automatic wide_t sat_neg(wide_t a);
    if (a == wide_t'({1'b1, 63'b0})) begin
      return wide_t'({1'b0, {63{1'b1}}});
    end
    return -a;
  endfunction

  // magnitude, most negative value gives 2^63
  function automatic logic [63:0] mag(wide_t v);
    return v[63] ? (64'd0 - 64'(v)) : 64'(v);
  endfunction

  // apply sign to a magnitude, clamped to +lim / -(lim+1)
  function automatic logic [63:0] from_mag(logic [63:0] m, logic neg, logic [63:0] lim);
    logic [63:0] mm;
    if (neg) begin
      mm = (m > lim + 64'd1) ? lim + 64'd1 : m;
      return 64'd0 - mm;
    end
    return (m > lim) ? lim : m;
  endfunction

  // column-major address of minor element (a,b) with row i and column j removed
  function automatic logic [3:0] minor_addr(logic [1:0] i, logic [1:0] j,
                                            logic [1:0] a, logic [1:0] b);
    logic [2:0] r;
    logic [2:0] c;
    r = {1'b0, a} + ((a >= i) ? 3'd1 : 3'd0);
    c = {1'b0, b} + ((b >= j) ? 3'd1 : 3'd0);
    return {c[1:0], r[1:0]};
  endfunction

  // left operand {row, col} of the minor for each product step
  function automatic logic [3:0] step_a(logic [3:0] s);
    unique case (s)
      4'd0:    return {2'd1, 2'd1};
      4'd1:    return {2'd1, 2'd2};
      4'd2:    return {2'd1, 2'd0};
      4'd3:    return {2'd1, 2'd2};
      4'd4:    return {2'd1, 2'd0};
      4'd5:    return {2'd1, 2'd1};
      4'd6:    return {2'd0, 2'd0};
      4'd7:    return {2'd0, 2'd1};
      default: return {2'd0, 2'd2};
    endcase
  endfunction

  // right operand {row, col} for the 2x2 product steps
  function automatic logic [3:0] step_b(logic [3:0] s);
    unique case (s)
      4'd0:    return {2'd2, 2'd2};
      4'd1:    return {2'd2, 2'd1};
      4'd2:    return {2'd2, 2'd2};
      4'd3:    return {2'd2, 2'd0};
      4'd4:    return {2'd2, 2'd1};
      default: return {2'd2, 2'd0};
    endcase
  endfunction

endpackage

// ===== rtl/m4adj_mul.sv =====
`timescale 1ns / 1ps
module m4adj_mul #(
  parameter int FRAC_BITS = m4adj_pkg::DEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  m4adj_pkg::wide_t  a,
  input  m4adj_pkg::wide_t  b,
  output logic              done,
  output m4adj_pkg::wide_t  p
);
  import m4adj_pkg::*;

  logic [63:0]  ma;
  logic [63:0]  mb;
  logic         neg;
  logic [127:0] prod;
  logic [1:0]   cnt;
  logic         busy;
  logic         fin;
  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [63:0]  q;

  // one 32x32 partial product per cycle
  always_comb begin
    pa = cnt[1] ? ma[63:32] : ma[31:0];
    pb = cnt[0] ? mb[63:32] : mb[31:0];
    pp = 64'(pa) * 64'(pb);
    unique case ({1'b0, cnt[1]} + {1'b0, cnt[0]})
      2'd0:    pp_sh = {64'b0, pp};
      2'd1:    pp_sh = {32'b0, pp, 32'b0};
      default: pp_sh = {pp, 64'b0};
    endcase
    q = prod[FRAC_BITS +: 64];
    if ((prod >> (64 + FRAC_BITS)) != 128'b0) begin
      q = '1;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= fin;
      fin  <= busy && (cnt == 2'd3);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 2'd0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      ma   <= mag(a);
      mb   <= mag(b);
      neg  <= a[63] ^ b[63];
      prod <= 128'b0;
    end else if (busy) begin
      prod <= prod + pp_sh;
    end
    if (fin) begin
      p <= wide_t'(from_mag(q, neg, S64_MAX_MAG));
    end
  end

endmodule

// ===== rtl/m4adj_div.sv =====
`timescale 1ns / 1ps
module m4adj_div #(
  parameter int ELEM_WIDTH = m4adj_pkg::DEF_ELEM_WIDTH,
  parameter int FRAC_BITS  = m4adj_pkg::DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  m4adj_pkg::wide_t      num,
  input  m4adj_pkg::wide_t      den,
  output logic                  done,
  output logic [ELEM_WIDTH-1:0] quot
);
  import m4adj_pkg::*;

  localparam logic [63:0] ELEM_MAX_MAG = (64'd1 << (ELEM_WIDTH - 1)) - 64'd1;

  logic [127:0] dvd;
  logic [63:0]  d;
  logic [63:0]  r;
  logic [63:0]  q;
  logic         ovf;
  logic         neg;
  logic [6:0]   cnt;
  logic         busy;
  logic         fin;
  logic [63:0]  rs;
  logic [63:0]  qs;
  logic         take;
  logic [63:0]  qf;

  // one restoring step
  always_comb begin
    rs   = {r[62:0], dvd[127]};
    qs   = {q[62:0], 1'b0};
    take = r[63] || (rs >= d);
    qf   = ovf ? '1 : q;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
    end else begin
      done <= fin;
      fin  <= busy && (cnt == 7'd127);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd127) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {64'b0, mag(num)} << FRAC_BITS;
      d   <= mag(den);
      neg <= num[63] ^ den[63];
      r   <= 64'b0;
      q   <= 64'b0;
      ovf <= 1'b0;
    end else if (busy) begin
      dvd <= {dvd[126:0], 1'b0};
      ovf <= ovf | q[63];
      r   <= take ? rs - d : rs;
      q   <= take ? (qs | 64'd1) : qs;
    end
    if (fin) begin
      quot <= ELEM_WIDTH'(from_mag(qf, neg, ELEM_MAX_MAG));
    end
  end

endmodule

// ===== rtl/matrix4_adjugate_inverse.sv =====
`timescale 1ns / 1ps
// 4x4 matrix inverse by the adjugate, signed fixed point with FRAC_BITS fraction bits.
// Sixteen elements go in column-major order on the slave stream, tlast on the sixteenth.
// The block then computes all sixteen 3x3 cofactors and the determinant with one shared
// 64x64 multiplier that takes four 32x32 partial products (148 products in all), and
// divides each cofactor by the determinant on a bit-serial restoring divider. From the
// last element to the last result, no element is taken. A singular matrix
// (|det| <= threshold) gives one item with tuser set instead of sixteen.
module matrix4_adjugate_inverse #(
  parameter int ELEM_WIDTH = m4adj_pkg::DEF_ELEM_WIDTH,
  parameter int FRAC_BITS  = m4adj_pkg::DEF_FRAC_BITS,
  localparam int S_W = ((ELEM_WIDTH + 7) / 8) * 8,
  localparam int M_W = ((2 * ELEM_WIDTH + 4 + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [m4adj_pkg::THR_WIDTH-1:0]  cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [S_W-1:0]                   s_tdata,   // element_value
  input  logic                             s_tlast,   // element_last
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [M_W-1:0]                   m_tdata,   // result_value, result_index,
                                                      // determinant_value
  output logic                             m_tuser,   // is_singular
  output logic                             m_tlast    // result_last
);
  import m4adj_pkg::*;

  localparam logic [63:0] ELEM_MAX_MAG = (64'd1 << (ELEM_WIDTH - 1)) - 64'd1;

  state_t state;
  state_t state_next;

  logic [ELEM_WIDTH-1:0] mat_store [16];
  logic [ELEM_WIDTH-1:0] mat_q;
  logic [3:0]            mat_rd_addr;
  wide_t                 cof_store [16];
  wide_t                 cof_q;
  logic [3:0]            cof_rd_addr;

  logic [THR_WIDTH-1:0]  threshold;
  logic [3:0]            load_count;
  logic [3:0]            cof_idx;
  logic [3:0]            step;
  logic [1:0]            det_i;
  logic                  det_phase;
  logic [3:0]            k;

  wide_t                 op_a;
  wide_t                 op_b;
  wide_t                 acc;
  wide_t                 t0;
  wide_t                 t1;
  wide_t                 t2;
  wide_t                 det;
  logic [ELEM_WIDTH-1:0] det_out;
  wide_t                 d_fin;

  logic                  mul_start;
  logic                  mul_done;
  wide_t                 mul_p;
  logic                  div_start;
  logic                  div_done;
  logic [ELEM_WIDTH-1:0] div_q;

  logic                  s_acc;
  logic                  out_free;
  logic                  load_out;
  logic [ELEM_WIDTH-1:0] out_val;
  logic [3:0]            out_idx;
  logic                  out_sing;
  logic                  out_last;
  logic                  singular;
  logic [3:0]            sa;
  logic [3:0]            sb;

  assign cfg_ready = 1'b1;
  assign s_acc     = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign singular  = mag(det) <= {48'b0, threshold};

  // operand addresses, right operand and signed cofactor sum for the current step
  always_comb begin
    sa = step_a(step);
    sb = step_b(step);
    if (det_phase) begin
      mat_rd_addr = {2'b00, det_i};
    end else if (state == ST_FETCH_B) begin
      mat_rd_addr = minor_addr(cof_idx[3:2], cof_idx[1:0], sb[3:2], sb[1:0]);
    end else begin
      mat_rd_addr = minor_addr(cof_idx[3:2], cof_idx[1:0], sa[3:2], sa[1:0]);
    end
    cof_rd_addr = (state == ST_DIV_FETCH || state == ST_DIV_GO) ? k : {det_i, 2'b00};
    if (det_phase) begin
      op_b = cof_q;
    end else begin
      unique case (step)
        4'd6:    op_b = t0;
        4'd7:    op_b = t1;
        4'd8:    op_b = t2;
        default: op_b = {{(64 - ELEM_WIDTH){mat_q[ELEM_WIDTH-1]}}, mat_q};
      endcase
    end
    d_fin = sat_add(acc, mul_p);
    if (cof_idx[2] ^ cof_idx[0]) begin
      d_fin = sat_neg(d_fin);
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    out_val    = '0;
    out_idx    = 4'd0;
    out_sing   = 1'b0;
    out_last   = 1'b0;
    unique case (state)
      ST_LOAD: begin
        s_tready = 1'b1;
        if (s_acc && s_tlast) state_next = ST_FETCH_A;
      end
      ST_FETCH_A: state_next = ST_FETCH_B;
      ST_FETCH_B: state_next = ST_MUL_GO;
      ST_MUL_GO: begin
        mul_start  = 1'b1;
        state_next = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: if (mul_done) state_next = ST_APPLY;
      ST_APPLY: begin
        state_next = (det_phase && det_i == 2'd3) ? ST_CHECK : ST_FETCH_A;
      end
      ST_CHECK: state_next = singular ? ST_SING_OUT : ST_DIV_FETCH;
      ST_SING_OUT: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_sing   = 1'b1;
          out_last   = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_DIV_FETCH: state_next = ST_DIV_GO;
      ST_DIV_GO: begin
        div_start  = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: if (div_done) state_next = ST_DIV_OUT;
      ST_DIV_OUT: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_val    = div_q;
          out_idx    = k;
          out_last   = (k == LAST_INDEX);
          state_next = (k == LAST_INDEX) ? ST_LOAD : ST_DIV_FETCH;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // state register and sequence counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      threshold  <= '0;
      load_count <= 4'd0;
      cof_idx    <= 4'd0;
      step       <= 4'd0;
      det_i      <= 2'd0;
      det_phase  <= 1'b0;
      k          <= 4'd0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) threshold <= cfg_data;
      if (s_acc) load_count <= s_tlast ? 4'd0 : load_count + 4'd1;
      if (state == ST_APPLY) begin
        if (det_phase) begin
          det_i <= det_i + 2'd1;
        end else if (step == LAST_STEP) begin
          step    <= 4'd0;
          cof_idx <= cof_idx + 4'd1;
          if (cof_idx == LAST_INDEX) begin
            det_phase <= 1'b1;
            det_i     <= 2'd0;
          end
        end else begin
          step <= step + 4'd1;
        end
      end
      if (state == ST_CHECK) k <= 4'd0;
      if (state == ST_DIV_OUT && load_out) k <= k + 4'd1;
      if (load_out && out_last) begin
        det_phase <= 1'b0;
        cof_idx   <= 4'd0;
        step      <= 4'd0;
        det_i     <= 2'd0;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // element and cofactor stores
  always_ff @(posedge clk) begin
    if (s_acc) mat_store[load_count] <= s_tdata[ELEM_WIDTH-1:0];
    mat_q <= mat_store[mat_rd_addr];
    if (state == ST_APPLY && !det_phase && step == LAST_STEP) cof_store[cof_idx] <= d_fin;
    cof_q <= cof_store[cof_rd_addr];
  end

  // accumulators and result register
  always_ff @(posedge clk) begin
    if (state == ST_FETCH_B) op_a <= {{(64 - ELEM_WIDTH){mat_q[ELEM_WIDTH-1]}}, mat_q};
    if (state == ST_FETCH_A && det_phase && det_i == 2'd0 && step == 4'd0) det <= '0;
    if (state == ST_APPLY) begin
      if (det_phase) begin
        det <= sat_add(det, mul_p);
      end else begin
        unique case (step)
          4'd1:    t0  <= sat_add(acc, sat_neg(mul_p));
          4'd3:    t1  <= sat_add(acc, sat_neg(mul_p));
          4'd5:    t2  <= sat_add(acc, sat_neg(mul_p));
          4'd7:    acc <= sat_add(acc, sat_neg(mul_p));
          default: acc <= mul_p;
        endcase
      end
    end
    if (state == ST_CHECK) det_out <= ELEM_WIDTH'(from_mag(mag(det), det[63], ELEM_MAX_MAG));
    if (load_out) begin
      m_tdata <= M_W'({det_out, out_idx, out_val});
      m_tuser <= out_sing;
      m_tlast <= out_last;
    end
  end

  m4adj_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (op_a),
    .b    (op_b),
    .done (mul_done),
    .p    (mul_p)
  );

  m4adj_div #(
    .ELEM_WIDTH(ELEM_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (cof_q),
    .den  (det),
    .done (div_done),
    .quot (div_q)
  );

  // a singular item is always the last of its matrix
  a_sing_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("singular item without last");

  // no element is taken once the last one is in
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("element taken during computation");

  // divider results arrive only while waiting for them
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV_WAIT)
    else $error("unexpected divider result");

  // multiplier results arrive only while waiting for them
  a_mul_done: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == ST_MUL_WAIT)
    else $error("unexpected product");

endmodule
